// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PRE_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define PRE_ASSERT(name, clk, rst_n, prop)
`define PRE_NEVER(name, clk, rst_n, expr)
`endif
`endif

// ----- rtl/pre_pkg.sv -----
// types and constants of the page replacement engine
package pre_pkg;

    localparam int FRAME_BITS    = 8;
    localparam int TIME_BITS     = 16;
    localparam int USE_BITS      = 16;
    localparam int FAULT_BITS    = 16;
    localparam int PAGE_BITS     = 6;
    localparam int KIND_BITS     = 2;
    localparam int STATUS_BITS   = 3;
    localparam int POLICY_BITS   = 2;
    localparam int CFG_DATA_BITS = 7;

    localparam logic [KIND_BITS-1:0] KIND_ACCESS = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PUSH   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [POLICY_BITS-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_BITS-1:0] POL_LRU  = 2'd1;
    localparam logic [POLICY_BITS-1:0] POL_LFU  = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FREE     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_REPLACED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NO_FRAME = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_LOADED   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd6;
    localparam logic [STATUS_BITS-1:0] ST_BAD      = 3'd7;

    localparam logic [0:0] CFG_POLICY = 1'b0;
    localparam logic [0:0] CFG_PAGES  = 1'b1;

    localparam logic [CFG_DATA_BITS-1:0] PAGES_IN_USE_RESET = 7'd64;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame_value;
        logic [TIME_BITS-1:0]  access_time;
    } t_req;

    typedef struct packed {
        logic [FRAME_BITS-1:0]  frame;
        logic [STATUS_BITS-1:0] status;
        logic [PAGE_BITS-1:0]   evicted_page;
        logic [FAULT_BITS-1:0]  fault_total;
    } t_rsp;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [TIME_BITS-1:0]  arrival;
        logic [TIME_BITS-1:0]  last_use;
        logic [USE_BITS-1:0]   uses;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic look;
        logic decide;
        logic scan;
        logic evict;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic access_ok;
        logic need_scan;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/pre_dp.sv -----
// datapath: page table, free frame stack, victim search and result register
`include "assert_macros.svh"
module pre_dp import pre_pkg::*; #(
    parameter int PAGES      = 64,
    parameter int POOL_DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  t_req                     i_in_req,
    input  logic                     i_cfg_valid,
    input  logic [0:0]               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output t_rsp                     o_out_rsp
);

    localparam int PW   = $clog2(PAGES);
    localparam int NW   = $clog2(PAGES + 1);
    localparam int CMPW = (NW > CFG_DATA_BITS) ? NW : CFG_DATA_BITS;
    localparam int SW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW   = $clog2(POOL_DEPTH + 1);

    logic [POLICY_BITS-1:0]   r_policy;
    logic [CFG_DATA_BITS-1:0] r_piu;
    t_req                     r_req;
    logic [PAGES-1:0]         r_valid;
    t_entry                   r_mem [PAGES];
    t_entry                   r_rd;
    logic [FRAME_BITS-1:0]    r_stk [POOL_DEPTH];
    logic [FRAME_BITS-1:0]    r_stk_rd;
    logic [CW-1:0]            r_fcnt;
    logic [FAULT_BITS-1:0]    r_fault;
    logic [PW-1:0]            r_idx;
    logic                     r_pend;
    logic                     r_pend_vld;
    logic [PW-1:0]            r_pend_idx;
    logic                     r_found;
    logic [PW-1:0]            r_best_idx;
    t_entry                   r_best;
    logic [FRAME_BITS-1:0]    r_res_frame;
    logic [STATUS_BITS-1:0]   r_res_status;
    logic [PAGE_BITS-1:0]     r_res_evict;
    t_rsp                     r_out;
    logic                     r_out_vld;

    logic [CMPW-1:0]     piu_x;
    logic [CMPW-1:0]     n_x;
    logic [NW-1:0]       n;
    logic [PW-1:0]       pidx;
    logic                page_ok;
    logic                hit;
    logic                better;
    logic                take;
    logic                load_free;
    logic                load_evict;
    logic                mem_we;
    logic                mem_re;
    logic [PW-1:0]       mem_raddr;
    t_entry              mem_wdata;
    logic [CW-1:0]       fcnt_m1;
    logic [USE_BITS-1:0] uses_inc;

    assign piu_x   = CMPW'(r_piu);
    assign n_x     = (piu_x > CMPW'(PAGES)) ? CMPW'(PAGES) : piu_x;
    assign n       = NW'(n_x);
    assign pidx    = PW'(r_req.page);
    assign page_ok = CMPW'(r_req.page) < n_x;
    assign hit     = r_valid[pidx];
    assign fcnt_m1 = r_fcnt - CW'(1);
    assign uses_inc = (r_rd.uses == '1) ? r_rd.uses : r_rd.uses + USE_BITS'(1);

    assign load_free  = i_cmd.decide && !hit && (r_fcnt != '0);
    assign load_evict = i_cmd.evict && r_found;

    assign o_sts.access_ok = (r_req.kind == KIND_ACCESS) && page_ok;
    assign o_sts.need_scan = !hit && (r_fcnt == '0);
    assign o_sts.scan_last = (NW'(r_idx) + NW'(1)) == n;
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

    always_comb begin
        unique case (r_policy)
            POL_LRU: better = r_rd.last_use < r_best.last_use;
            POL_LFU: begin
                if (r_rd.uses != r_best.uses) begin
                    better = r_rd.uses < r_best.uses;
                end else begin
                    better = r_rd.arrival < r_best.arrival;
                end
            end
            default: better = r_rd.arrival < r_best.arrival;
        endcase
    end

    assign take = r_pend && r_pend_vld && (!r_found || better);

    always_comb begin
        mem_wdata = '{frame: r_rd.frame, arrival: r_rd.arrival,
                      last_use: r_req.access_time, uses: uses_inc};
        if (load_free) begin
            mem_wdata = '{frame: r_stk_rd, arrival: r_req.access_time,
                          last_use: r_req.access_time, uses: USE_BITS'(1)};
        end else if (i_cmd.evict) begin
            mem_wdata = '{frame: r_best.frame, arrival: r_req.access_time,
                          last_use: r_req.access_time, uses: USE_BITS'(1)};
        end
    end

    assign mem_we    = (i_cmd.decide && (hit || (r_fcnt != '0))) || load_evict;
    assign mem_re    = i_cmd.look || i_cmd.scan;
    assign mem_raddr = i_cmd.scan ? r_idx : pidx;

    // page table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[pidx] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // free frame stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.look && (r_req.kind == KIND_PUSH) && (r_fcnt != CW'(POOL_DEPTH))) begin
            r_stk[r_fcnt[SW-1:0]] <= r_req.frame_value;
        end
        if (i_cmd.look) begin
            r_stk_rd <= r_stk[fcnt_m1[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FIFO;
            r_piu     <= PAGES_IN_USE_RESET;
            r_valid   <= '0;
            r_fcnt    <= '0;
            r_fault   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_POLICY: r_policy <= i_cfg_data[POLICY_BITS-1:0];
                    CFG_PAGES:  r_piu    <= i_cfg_data;
                    default:    r_piu    <= r_piu;
                endcase
            end
            if (i_cmd.look && (r_req.kind == KIND_CLEAR)) begin
                r_valid <= '0;
                r_fcnt  <= '0;
                r_fault <= '0;
            end else begin
                if (load_evict) begin
                    r_valid <= (r_valid & ~(PAGES'(1) << r_best_idx)) | (PAGES'(1) << pidx);
                end else if (load_free) begin
                    r_valid[pidx] <= 1'b1;
                end
                if (i_cmd.look && (r_req.kind == KIND_PUSH)
                    && (r_fcnt != CW'(POOL_DEPTH))) begin
                    r_fcnt <= r_fcnt + CW'(1);
                end else if (load_free) begin
                    r_fcnt <= fcnt_m1;
                end
                if (i_cmd.decide && !hit && (r_fault != '1)) begin
                    r_fault <= r_fault + FAULT_BITS'(1);
                end
            end
            if (i_cmd.decide) begin
                r_idx <= '0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + PW'(1);
            end
            r_pend <= i_cmd.scan;
            if (i_cmd.decide) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_in_req;
        end
        if (i_cmd.scan) begin
            r_pend_idx <= r_idx;
            r_pend_vld <= r_valid[r_idx];
        end
        if (take) begin
            r_best     <= r_rd;
            r_best_idx <= r_pend_idx;
        end
        if (i_cmd.look) begin
            r_res_frame <= '0;
            r_res_evict <= '0;
            unique case (r_req.kind)
                KIND_ACCESS: r_res_status <= ST_BAD;
                KIND_PUSH: begin
                    r_res_status <= (r_fcnt != CW'(POOL_DEPTH)) ? ST_LOADED : ST_FULL;
                end
                KIND_CLEAR:  r_res_status <= ST_CLEARED;
                default:     r_res_status <= ST_BAD;
            endcase
        end
        if (i_cmd.decide) begin
            if (hit) begin
                r_res_frame  <= r_rd.frame;
                r_res_status <= ST_HIT;
            end else if (r_fcnt != '0) begin
                r_res_frame  <= r_stk_rd;
                r_res_status <= ST_FREE;
            end
        end
        if (i_cmd.evict) begin
            if (r_found) begin
                r_res_frame  <= r_best.frame;
                r_res_status <= ST_REPLACED;
                r_res_evict  <= PAGE_BITS'(r_best_idx);
            end else begin
                r_res_status <= ST_NO_FRAME;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= '{frame: r_res_frame, status: r_res_status,
                       evicted_page: r_res_evict, fault_total: r_fault};
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

    `PRE_NEVER(a_fcnt_range, i_clk, i_rst_n, r_fcnt > CW'(POOL_DEPTH))
    `PRE_ASSERT(a_scan_idx, i_clk, i_rst_n, i_cmd.scan |-> (NW'(r_idx) < n))
    `PRE_ASSERT(a_out_load, i_clk, i_rst_n, i_cmd.out_load |=> o_out_valid)

endmodule

// ----- rtl/pre_ctrl.sv -----
// controller state machine sequencing lookup, victim search and result
`include "assert_macros.svh"
module pre_ctrl import pre_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOOK   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_EVICT  = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_LOOK;
            S_LOOK:   n_state = i_sts.access_ok ? S_DECIDE : S_DONE;
            S_DECIDE: n_state = i_sts.need_scan ? S_SCAN : S_DONE;
            S_SCAN:   if (i_sts.scan_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_EVICT;
            S_EVICT:  n_state = S_DONE;
            S_DONE:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.look     = (r_state == S_LOOK);
    assign o_cmd.decide   = (r_state == S_DECIDE);
    assign o_cmd.scan     = (r_state == S_SCAN);
    assign o_cmd.evict    = (r_state == S_EVICT);
    assign o_cmd.out_load = (r_state == S_DONE) && i_sts.out_free;

    `PRE_ASSERT(a_evict_after_drain, i_clk, i_rst_n, o_cmd.evict |-> $past(r_state == S_DRAIN))
    `PRE_ASSERT(a_state_onehot, i_clk, i_rst_n, $onehot(r_state))
    `PRE_ASSERT(a_accept_look, i_clk, i_rst_n, o_cmd.accept |=> o_cmd.look)

endmodule

// ----- rtl/page_replacement_engine_top.sv -----
// page replacement engine: a victim search covers min(pages_in_use, PAGES) page table entries
// a request enters, then lookup, decide (in-range accesses only), victim search and result register stages follow
// the victim search reads one page table entry per cycle through the single memory read port
// one request at a time; the next is taken once the result sits in the output register
// synchronous active-low reset: table invalid, free stack empty, fault count zero, no clear pass
module page_replacement_engine_top import pre_pkg::*; #(
    parameter int PAGES      = 64,
    parameter int POOL_DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  t_req                     i_in_req,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output t_rsp                     o_out_rsp,
    input  logic                     i_out_stall,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [0:0]               i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    pre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    pre_dp #(
        .PAGES      (PAGES),
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_req    (i_in_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

// ----- sim/page_replacement_engine_top_tb.sv -----
// self-checking testbench of the page replacement engine: random and directed requests
module page_replacement_engine_top_tb;
    import pre_pkg::*;

    localparam int NUM_PAGES  = 64;
    localparam int POOL_SLOTS = 64;
    localparam logic [KIND_BITS-1:0]   KIND_UNUSED = 2'd3;
    localparam logic [POLICY_BITS-1:0] POL_SPARE   = 2'd3;

    typedef struct {
        t_req req;
        bit   drain;
    } queued_req_t;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    t_req                     i_in_req    = '0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    t_rsp                     o_out_rsp;
    logic                     i_out_stall = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [0:0]               i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    page_replacement_engine_top #(
        .PAGES      (NUM_PAGES),
        .POOL_DEPTH (POOL_SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // page table mirror
    bit                     tbl_valid   [NUM_PAGES];
    logic [FRAME_BITS-1:0]  tbl_frame   [NUM_PAGES];
    logic [TIME_BITS-1:0]   tbl_arrival [NUM_PAGES];
    logic [TIME_BITS-1:0]   tbl_last    [NUM_PAGES];
    logic [USE_BITS-1:0]    tbl_uses    [NUM_PAGES];
    logic [FRAME_BITS-1:0]  pool        [POOL_SLOTS];
    int unsigned            pool_fill   = 0;
    bit [FAULT_BITS-1:0]    fault_tally = '0;
    logic [POLICY_BITS-1:0] tbl_policy  = POL_FIFO;
    logic [CFG_DATA_BITS-1:0] tbl_limit = PAGES_IN_USE_RESET;

    queued_req_t pending_reqs[$];
    t_rsp        expected_rsps[$];
    queued_req_t send_item;
    t_rsp        predicted;

    int unsigned send_gap       = 0;
    int unsigned stall_left     = 0;
    int unsigned stall_draw;
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          req_taken      = 1'b0;
    bit          rsp_taken      = 1'b0;
    bit          cfg_taken      = 1'b0;
    int unsigned fail_count     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("page_replacement_engine_top regression: fail");
        $finish;
    end

    function automatic int unsigned draw_wait(input bit on);
        if (on)
            return $urandom_range(0, 18);
        return 0;
    endfunction

    function automatic bit beats(input int unsigned c, input int unsigned b);
        case (tbl_policy)
            POL_LRU: return tbl_last[c] < tbl_last[b];
            POL_LFU: begin
                if (tbl_uses[c] != tbl_uses[b])
                    return tbl_uses[c] < tbl_uses[b];
                return tbl_arrival[c] < tbl_arrival[b];
            end
            default: return tbl_arrival[c] < tbl_arrival[b];
        endcase
    endfunction

    task automatic load_page(input int unsigned p, input logic [FRAME_BITS-1:0] f,
                             input logic [TIME_BITS-1:0] t);
        tbl_valid[p]   = 1'b1;
        tbl_frame[p]   = f;
        tbl_arrival[p] = t;
        tbl_last[p]    = t;
        tbl_uses[p]    = USE_BITS'(1);
    endtask

    task automatic predict_page_result(input t_req r, output t_rsp y);
        int unsigned n;
        int unsigned best;
        int unsigned i;
        bit          found;
        y = '0;
        y.status = ST_BAD;
        n = (tbl_limit > NUM_PAGES) ? NUM_PAGES : tbl_limit;
        case (r.kind)
            KIND_ACCESS: begin
                if (r.page < n) begin
                    if (tbl_valid[r.page]) begin
                        tbl_last[r.page] = r.access_time;
                        if (tbl_uses[r.page] != '1)
                            tbl_uses[r.page] = tbl_uses[r.page] + 1'b1;
                        y.frame  = tbl_frame[r.page];
                        y.status = ST_HIT;
                    end else begin
                        if (fault_tally != '1)
                            fault_tally = fault_tally + 1'b1;
                        if (pool_fill > 0) begin
                            pool_fill = pool_fill - 1;
                            y.frame   = pool[pool_fill];
                            y.status  = ST_FREE;
                            load_page(r.page, y.frame, r.access_time);
                        end else begin
                            found = 1'b0;
                            best  = 0;
                            for (i = 0; i < n; i++) begin
                                if (tbl_valid[i] && (!found || beats(i, best))) begin
                                    best  = i;
                                    found = 1'b1;
                                end
                            end
                            if (found) begin
                                y.frame          = tbl_frame[best];
                                tbl_valid[best]  = 1'b0;
                                load_page(r.page, y.frame, r.access_time);
                                y.evicted_page   = PAGE_BITS'(best);
                                y.status         = ST_REPLACED;
                            end else begin
                                y.status = ST_NO_FRAME;
                            end
                        end
                    end
                end
            end
            KIND_PUSH: begin
                if (pool_fill < POOL_SLOTS) begin
                    pool[pool_fill] = r.frame_value;
                    pool_fill       = pool_fill + 1;
                    y.status        = ST_LOADED;
                end else begin
                    y.status = ST_FULL;
                end
            end
            KIND_CLEAR: begin
                for (i = 0; i < NUM_PAGES; i++)
                    tbl_valid[i] = 1'b0;
                pool_fill   = 0;
                fault_tally = '0;
                y.status    = ST_CLEARED;
            end
            default: ;
        endcase
        y.fault_total = fault_tally;
    endtask

    task automatic report(input string what, input logic [FAULT_BITS-1:0] want_v,
                          input logic [FAULT_BITS-1:0] got_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
    endtask

    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (expected_rsps.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
            want = expected_rsps.pop_front();
            if (got.frame !== want.frame)
                report("frame", FAULT_BITS'(want.frame), FAULT_BITS'(got.frame));
            if (got.status !== want.status)
                report("status", FAULT_BITS'(want.status), FAULT_BITS'(got.status));
            if (got.evicted_page !== want.evicted_page)
                report("evicted_page", FAULT_BITS'(want.evicted_page),
                       FAULT_BITS'(got.evicted_page));
            if (got.fault_total !== want.fault_total)
                report("fault_total", want.fault_total, got.fault_total);
        end
    endtask

    // monitor: everything is sampled at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            rsp_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            req_taken <= i_in_valid && !o_in_stall;
            rsp_taken <= o_out_valid && !i_out_stall;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (o_out_valid && !i_out_stall)
                check_result(o_out_rsp);
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_POLICY)
                    tbl_policy = i_cfg_data[POLICY_BITS-1:0];
                else
                    tbl_limit = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                predict_page_result(i_in_req, predicted);
                expected_rsps.push_back(predicted);
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_in_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
                send_item   = pending_reqs.pop_front();
                i_in_req   <= send_item.req;
                i_in_valid <= 1'b1;
                send_gap   <= draw_wait(sender_idles);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result stall driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (rsp_taken) begin
            stall_draw   = draw_wait(receiver_idles);
            i_out_stall <= (stall_draw > 0);
            stall_left  <= (stall_draw > 0) ? stall_draw - 1 : 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_req(input logic [KIND_BITS-1:0] k, input int unsigned pg,
                             input int unsigned fv, input int unsigned t, input bit hold);
        queued_req_t item;
        item.req.kind        = k;
        item.req.page        = PAGE_BITS'(pg);
        item.req.frame_value = FRAME_BITS'(fv);
        item.req.access_time = TIME_BITS'(t);
        item.drain           = hold;
        pending_reqs.push_back(item);
    endtask

    task automatic drain_all();
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || i_in_valid);
    endtask

    task automatic random_phase(input logic [POLICY_BITS-1:0] pol, input int unsigned lim,
                                input int unsigned count, input int unsigned time_mode,
                                input bit calm);
        int unsigned n;
        int unsigned k;
        int unsigned pg;
        int unsigned stamp;
        int unsigned j;
        bit          hold;
        sender_idles   = !calm;
        receiver_idles = !calm;
        write_reg(CFG_POLICY, {5'($urandom), pol});
        write_reg(CFG_PAGES, CFG_DATA_BITS'(lim));
        n = (lim > NUM_PAGES) ? NUM_PAGES : lim;
        stamp = $urandom_range(0, 65535);
        for (j = 0; j < count; j++) begin
            case (time_mode)
                0:       stamp = $urandom_range(0, 65535);
                1:       stamp = (stamp + $urandom_range(0, 3)) & 16'hFFFF;
                default: stamp = $urandom_range(0, 3);
            endcase
            hold = (j == 10) || ($urandom_range(0, 49) == 0);
            pg = (n > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, n - 1)
                                                      : $urandom_range(0, 63);
            k = $urandom_range(0, 99);
            if (k < 70)
                queue_req(KIND_ACCESS, pg, $urandom_range(0, 255), stamp, hold);
            else if (k < 93)
                queue_req(KIND_PUSH, $urandom_range(0, 63), $urandom_range(0, 255), stamp, hold);
            else if (k < 96)
                queue_req(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 255), stamp, hold);
            else
                queue_req(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 255), stamp,
                          hold);
        end
        drain_all();
    endtask

    initial begin
        int unsigned lims [12];
        int unsigned ph;
        int unsigned j;
        lims = '{64, 4, 1, 2, 8, 16, 63, 3, 127, 5, 64, 32};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config
        queue_req(KIND_ACCESS, 0, 0, 0, 0);
        queue_req(KIND_UNUSED, 63, 255, 16'hFFFF, 0);
        queue_req(KIND_PUSH, 0, 255, 0, 0);
        queue_req(KIND_PUSH, 63, 0, 16'hFFFF, 0);
        queue_req(KIND_ACCESS, 63, 255, 16'hFFFF, 0);
        queue_req(KIND_ACCESS, 63, 0, 0, 0);
        queue_req(KIND_ACCESS, 0, 0, 1, 0);
        queue_req(KIND_ACCESS, 5, 0, 2, 1);
        queue_req(KIND_PUSH, 1, 8'hA5, 3, 0);
        queue_req(KIND_CLEAR, 0, 0, 0, 0);
        queue_req(KIND_ACCESS, 1, 0, 4, 0);
        drain_all();
        write_reg(CFG_PAGES, CFG_DATA_BITS'(2));
        queue_req(KIND_ACCESS, 2, 0, 5, 0);
        queue_req(KIND_ACCESS, 63, 0, 6, 0);
        queue_req(KIND_ACCESS, 1, 0, 7, 0);
        drain_all();
        write_reg(CFG_PAGES, CFG_DATA_BITS'(0));
        queue_req(KIND_ACCESS, 0, 0, 8, 0);
        drain_all();
        write_reg(CFG_PAGES, CFG_DATA_BITS'(127));
        write_reg(CFG_POLICY, CFG_DATA_BITS'(POL_SPARE));
        queue_req(KIND_PUSH, 0, 7, 0, 0);
        queue_req(KIND_ACCESS, 63, 0, 16'hFFFF, 0);
        queue_req(KIND_ACCESS, 62, 0, 0, 0);
        drain_all();

        // random phases over policies and table sizes
        for (ph = 0; ph < 12; ph++)
            random_phase(POLICY_BITS'(ph % 4), lims[ph], 105, ph % 3, (ph % 3) == 2);
        random_phase(POL_LRU, 0, 25, 0, 0);

        // fill the free pool past its depth
        queue_req(KIND_CLEAR, 0, 0, 0, 0);
        for (j = 0; j < POOL_SLOTS + 2; j++)
            queue_req(KIND_PUSH, $urandom_range(0, 63), $urandom_range(0, 255), 0, 0);
        drain_all();
        random_phase(POL_LFU, 8, 120, 1, 0);

        random_phase(POL_FIFO, 64, 80, 0, 0);

        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("page_replacement_engine_top regression: pass");
        else
            $display("page_replacement_engine_top regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pre_pkg.sv
rtl/pre_dp.sv
rtl/pre_ctrl.sv
rtl/page_replacement_engine_top.sv
sim/page_replacement_engine_top_tb.sv
